[sv/tcgr_pkg.sv]
`default_nettype none

package tcgr_pkg;

   localparam int unsigned CODE_W  = 8;
   localparam int unsigned COORD_W = 12;
   localparam int unsigned CSR_W   = 13;
   localparam int unsigned COL_W   = 9;
   localparam int unsigned ROW_W   = 8;

   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam logic [CSR_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CSR_W-1:0] HEIGHT_RESET = 13'd480;

   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_ONE   = 8'd49;
   localparam logic [7:0] CHAR_A     = 8'd65;
   localparam logic [7:0] CHAR_F     = 8'd70;
   localparam logic [7:0] CHAR_DEL   = 8'd127;

   localparam logic [9:0] COL_CAP = 10'd512;
   localparam logic [8:0] ROW_CAP = 9'd256;

   typedef enum logic [2:0] {
      GLYPH_BLANK,
      GLYPH_BOX,
      GLYPH_ONE,
      GLYPH_A,
      GLYPH_F
   } glyph_type;

   typedef struct packed {
      logic [CODE_W-1:0] char_code;
      logic              end_of_string;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [7:0]         row_bits;
      logic               present_frame;
      logic               last_of_run;
   } rsp_type;

   localparam logic [7:0] FONT_BOX_C [16] = '{
      8'h00, 8'h00, 8'h7e, 8'h42, 8'h42, 8'h42, 8'h42, 8'h42,
      8'h42, 8'h42, 8'h42, 8'h7e, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] FONT_ONE_C [16] = '{
      8'h00, 8'h00, 8'h08, 8'h18, 8'h28, 8'h08, 8'h08, 8'h08,
      8'h08, 8'h08, 8'h08, 8'h3e, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] FONT_A_C [16] = '{
      8'h00, 8'h00, 8'h18, 8'h24, 8'h24, 8'h42, 8'h42, 8'h7e,
      8'h42, 8'h42, 8'h42, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] FONT_F_C [16] = '{
      8'h00, 8'h00, 8'h7e, 8'h40, 8'h40, 8'h40, 8'h7c, 8'h40,
      8'h40, 8'h40, 8'h40, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00};

   function automatic glyph_type pick_glyph(input logic [7:0] code);
      glyph_type g;
      if (code > CHAR_DEL) begin
         g = GLYPH_BOX;
      end else if (code == CHAR_ONE) begin
         g = GLYPH_ONE;
      end else if (code == CHAR_A) begin
         g = GLYPH_A;
      end else if (code == CHAR_F) begin
         g = GLYPH_F;
      end else if (code > CHAR_SPACE && code < CHAR_DEL) begin
         g = GLYPH_BOX;
      end else begin
         g = GLYPH_BLANK;
      end
      return g;
   endfunction

   function automatic logic [7:0] glyph_row(input glyph_type g, input logic [3:0] r);
      logic [7:0] bits;
      case (g)
         GLYPH_BOX: bits = FONT_BOX_C[r];
         GLYPH_ONE: bits = FONT_ONE_C[r];
         GLYPH_A:   bits = FONT_A_C[r];
         GLYPH_F:   bits = FONT_F_C[r];
         default:   bits = 8'h00;
      endcase
      return bits;
   endfunction

endpackage

`default_nettype wire

[sv/text_console_glyph_renderer.sv]
// pipeline: job registers, font rom read stage, output register
// throughput: one result beat per cycle unless the output stalls; a drawn character gives
//   16 beats, plus one present beat when it ends a string; the next character is taken
//   as its last beat leaves; the row counter walks the font rom one glyph row per cycle
// characters that give no beat are taken one per cycle while no job is busy
// reset (synchronous): cursor to column 0 row 0, enable 0, width 640, height 480, no beats
`default_nettype none

module text_console_glyph_renderer #(
   parameter int unsigned MAX_DISPLAY_WIDTH  = 4096,
   parameter int unsigned MAX_DISPLAY_HEIGHT = 4096
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire tcgr_pkg::req_type       req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      tcgr_pkg::rsp_type       rsp_data,
   input  wire logic                    csr_we,
   input  wire logic [1:0]              csr_index,
   input  wire logic [tcgr_pkg::CSR_W-1:0] csr_wdata
);
   import tcgr_pkg::*;

   localparam logic [13:0] MAX_W = 14'(MAX_DISPLAY_WIDTH);
   localparam logic [13:0] MAX_H = 14'(MAX_DISPLAY_HEIGHT);

   logic               enable_ff;
   logic [CSR_W-1:0]   width_ff;
   logic [CSR_W-1:0]   height_ff;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;

   logic               job_busy_ff;
   logic               job_draw_ff;
   logic               job_eos_ff;
   logic [3:0]         job_row_ff;
   logic [COORD_W-1:0] job_x_ff;
   logic [COORD_W-1:0] job_y_ff;
   glyph_type          job_glyph_ff;

   logic               s1_valid_ff;
   logic [COORD_W-1:0] s1_x_ff;
   logic [COORD_W-1:0] s1_y_ff;
   logic [7:0]         s1_bits_ff;
   logic               s1_present_ff;
   logic               s1_last_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // display geometry
   logic [CSR_W-1:0] dw_c, dh_c;
   logic [9:0]       cols;
   logic [8:0]       rows;
   logic             active;

   always_comb begin
      dw_c = ({1'b0, width_ff} > MAX_W) ? MAX_W[CSR_W-1:0] : width_ff;
      dh_c = ({1'b0, height_ff} > MAX_H) ? MAX_H[CSR_W-1:0] : height_ff;
      cols = (dw_c[12:3] > COL_CAP) ? COL_CAP : dw_c[12:3];
      rows = (dh_c[12:4] > ROW_CAP) ? ROW_CAP : dh_c[12:4];
      active = enable_ff && (cols != 10'd0) && (rows != 9'd0);
   end

   // per-character decode at the cursor
   logic             is_cr, is_lf, is_print, fits, draw, job_new;
   logic [COL_W-1:0] col_inc;
   logic [ROW_W-1:0] row_nl;
   logic             wrap;
   logic [13:0]      x_end, y_end;

   always_comb begin
      is_cr    = (req_data.char_code == CHAR_CR);
      is_lf    = (req_data.char_code == CHAR_LF);
      is_print = !is_cr && !is_lf;
      x_end    = {2'b00, cur_col_ff, 3'b000} + 14'd8;
      y_end    = {2'b00, cur_row_ff, 4'b0000} + 14'd16;
      fits     = (x_end <= {1'b0, dw_c}) && (y_end <= {1'b0, dh_c});
      draw     = active && is_print && fits;
      job_new  = draw || (active && req_data.end_of_string);
      col_inc  = cur_col_ff + COL_W'(1);
      wrap     = ({1'b0, col_inc} >= cols) || (col_inc == '0);
      row_nl   = (({1'b0, cur_row_ff} + 9'd1) < rows) ? cur_row_ff + ROW_W'(1) : cur_row_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (active) begin
         if (is_lf) begin
            cur_col_in = '0;
            cur_row_in = row_nl;
         end else if (is_print) begin
            if (wrap) begin
               cur_col_in = '0;
               cur_row_in = row_nl;
            end else begin
               cur_col_in = col_inc;
            end
         end
      end
   end

   // beat generator
   logic adv, beat_final, job_done, req_acc;

   always_comb begin
      adv        = !rsp_valid_ff || rsp_ready;
      beat_final = job_draw_ff ? ((job_row_ff == 4'hf) && !job_eos_ff) : 1'b1;
      job_done   = job_busy_ff && beat_final;
      req_ready  = !job_busy_ff || (adv && job_done);
      req_acc    = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff  <= '0;
         cur_row_ff  <= '0;
         job_busy_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            cur_col_ff  <= cur_col_in;
            cur_row_ff  <= cur_row_in;
            job_busy_ff <= job_new;
         end else if (adv && job_done) begin
            job_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         job_draw_ff  <= draw;
         job_eos_ff   <= req_data.end_of_string;
         job_row_ff   <= 4'h0;
         job_x_ff     <= {cur_col_ff, 3'b000};
         job_y_ff     <= {cur_row_ff, 4'b0000};
         job_glyph_ff <= pick_glyph(req_data.char_code);
      end else if (adv && job_busy_ff && job_draw_ff) begin
         job_row_ff <= job_row_ff + 4'h1;
         if (job_row_ff == 4'hf) begin
            job_draw_ff <= 1'b0;
         end
      end
   end

   // font rom read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= job_busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_present_ff <= !job_draw_ff;
         s1_last_ff    <= beat_final;
         s1_x_ff       <= job_draw_ff ? job_x_ff : '0;
         s1_y_ff       <= job_draw_ff ? {job_y_ff[COORD_W-1:4], job_row_ff} : '0;
         s1_bits_ff    <= job_draw_ff ? glyph_row(job_glyph_ff, job_row_ff) : 8'h00;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.pixel_x       <= s1_x_ff;
         rsp_data_ff.pixel_y       <= s1_y_ff;
         rsp_data_ff.row_bits      <= s1_bits_ff;
         rsp_data_ff.present_frame <= s1_present_ff;
         rsp_data_ff.last_of_run   <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_present_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.present_frame |-> rsp_data.last_of_run &&
         rsp_data.pixel_x == '0 && rsp_data.pixel_y == '0 && rsp_data.row_bits == 8'h00)
      else $error("present beat not final or not cleared");

   a_present_phase: assert property (@(posedge clock) disable iff (reset)
      job_busy_ff && !job_draw_ff |-> job_eos_ff)
      else $error("present phase without end of string");

   a_blank_margin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.present_frame &&
         (rsp_data.pixel_y[3:0] <= 4'd1 || rsp_data.pixel_y[3:0] >= 4'd12)
         |-> rsp_data.row_bits == 8'h00)
      else $error("glyph row out of step with pixel_y");
`endif

endmodule

`default_nettype wire
